[hdl/fcmc_pkg.sv]
// Package for the frequency counter measure controller.
// Holds the poll and result beat types and the phase codes.
// No dependencies.
`default_nettype none

package fcmc_pkg;

    localparam int CountWidth = 32;
    localparam int ByteWidth  = 8;
    localparam int SelWidth   = 2;
    localparam int SentWidth  = 4;

    localparam logic [ByteWidth-1:0] StartMask    = 8'h80;
    localparam logic [ByteWidth-1:0] ChannelMask  = 8'h03;
    localparam logic [ByteWidth-1:0] TimebaseMask = 8'h0C;
    localparam logic [ByteWidth-1:0] IndexMask    = 8'h70;
    localparam logic [SentWidth-1:0] SentOne      = 4'h1;

    localparam logic [SentWidth-1:0] SentMeasLoad = 4'd0;
    localparam logic [SentWidth-1:0] SentRefLoad  = 4'd4;
    localparam logic [SentWidth-1:0] SentDone     = 4'd8;

    // Phase codes as seen on the result port.
    localparam logic [1:0] PhaseCodeStartup  = 2'd0;
    localparam logic [1:0] PhaseCodeIdle     = 2'd1;
    localparam logic [1:0] PhaseCodeMeasure  = 2'd2;
    localparam logic [1:0] PhaseCodeTransmit = 2'd3;

    typedef enum logic [3:0] {
        PH_STARTUP  = 4'b0001,
        PH_IDLE     = 4'b0010,
        PH_MEASURE  = 4'b0100,
        PH_TRANSMIT = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [ByteWidth-1:0]  rx_byte;
        logic                  meas_valid;
        logic [CountWidth-1:0] meas_count;
        logic [CountWidth-1:0] ref_count;
        logic                  uart_busy;
    } poll_t;

    typedef struct packed {
        logic [SelWidth-1:0]  channel_sel;
        logic [SelWidth-1:0]  timebase_sel;
        logic [ByteWidth-1:0] led_byte;
        logic                 start_level;
        logic                 reset_level;
        logic [ByteWidth-1:0] tx_byte;
        logic                 tx_strobe;
        logic [1:0]           phase;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_STARTUP:  code = PhaseCodeStartup;
            PH_IDLE:     code = PhaseCodeIdle;
            PH_MEASURE:  code = PhaseCodeMeasure;
            PH_TRANSMIT: code = PhaseCodeTransmit;
            default:     code = PhaseCodeStartup;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[hdl/fcmc_in_reg.sv]
// Input register stage for the measure controller.
// Captures one poll beat and holds it until the control stage takes it.
// Depends on fcmc_pkg.
`default_nettype none

module fcmc_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire fcmc_pkg::poll_t s_item,
    output logic               item_valid,
    output fcmc_pkg::poll_t    item,
    input  wire logic          item_take
);
    import fcmc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    poll_t item_reg;

    // The stage frees up in the same cycle its beat is taken.
    assign s_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

[hdl/fcmc_fsm.sv]
// Phase sequencer, capture and byte shifter of the measure controller,
// with the result register. Depends on fcmc_pkg.
`default_nettype none

module fcmc_fsm (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_valid,
    input  wire fcmc_pkg::poll_t item,
    output logic                 item_take,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output fcmc_pkg::result_t    result
);
    import fcmc_pkg::*;

    phase_t                phase_reg,     phase_next;
    logic [SentWidth-1:0]  sent_reg,      sent_next;
    logic [CountWidth-1:0] shift_reg,     shift_next;
    logic [CountWidth-1:0] meas_reg,      meas_next;
    logic [CountWidth-1:0] ref_reg,       ref_next;
    logic [SelWidth-1:0]   channel_reg,   channel_next;
    logic [SelWidth-1:0]   timebase_reg,  timebase_next;
    logic [ByteWidth-1:0]  led_reg,       led_next;
    logic                  start_reg,     start_next;
    logic                  rst_line_reg,  rst_line_next;
    logic [ByteWidth-1:0]  tx_reg,        tx_next;
    logic                  strobe;
    logic [CountWidth-1:0] word;
    logic [SentWidth-1:0]  echo_index;

    logic    m_valid_reg, m_valid_next;
    result_t result_reg,  result_next;

    assign item_take  = item_valid && (!m_valid_reg || m_ready);
    assign echo_index = {1'b0, 3'((item.rx_byte & IndexMask) >> 4)};

    always_comb begin
        phase_next    = phase_reg;
        sent_next     = sent_reg;
        shift_next    = shift_reg;
        meas_next     = meas_reg;
        ref_next      = ref_reg;
        channel_next  = channel_reg;
        timebase_next = timebase_reg;
        led_next      = led_reg;
        start_next    = start_reg;
        rst_line_next = rst_line_reg;
        tx_next       = tx_reg;
        strobe        = 1'b0;
        word          = shift_reg;

        unique case (phase_reg)
            PH_STARTUP: begin
                phase_next = PH_IDLE;
            end
            PH_IDLE: begin
                if ((item.rx_byte & StartMask) != '0) begin
                    channel_next  = SelWidth'(item.rx_byte & ChannelMask);
                    timebase_next = SelWidth'((item.rx_byte & TimebaseMask) >> 2);
                    led_next      = item.rx_byte;
                    rst_line_next = 1'b0;
                    start_next    = 1'b1;
                    phase_next    = PH_MEASURE;
                end
            end
            PH_MEASURE: begin
                if (item.meas_valid) begin
                    start_next    = 1'b0;
                    meas_next     = item.meas_count;
                    ref_next      = item.ref_count;
                    sent_next     = '0;
                    rst_line_next = 1'b1;
                    phase_next    = PH_TRANSMIT;
                end
            end
            PH_TRANSMIT: begin
                if (!item.uart_busy) begin
                    start_next = 1'b0;
                    // The measured count goes first, then the reference count.
                    if (sent_reg == SentMeasLoad) begin
                        word = meas_reg;
                    end
                    if (sent_reg == SentRefLoad) begin
                        word = ref_reg;
                    end
                    if (sent_reg == SentDone) begin
                        tx_next    = '0;
                        phase_next = PH_IDLE;
                    end
                    shift_next = word;
                    if (echo_index == sent_reg) begin
                        tx_next    = word[CountWidth-1 -: ByteWidth];
                        strobe     = 1'b1;
                        shift_next = {word[CountWidth-ByteWidth-1:0], {ByteWidth{1'b0}}};
                        sent_next  = sent_reg + SentOne;
                    end
                end
            end
            default: begin
                phase_next = PH_STARTUP;
            end
        endcase
    end

    always_comb begin
        result_next.channel_sel  = channel_next;
        result_next.timebase_sel = timebase_next;
        result_next.led_byte     = led_next;
        result_next.start_level  = start_next;
        result_next.reset_level  = rst_line_next;
        result_next.tx_byte      = tx_next;
        result_next.tx_strobe    = strobe;
        result_next.phase        = phase_code(phase_next);

        m_valid_next = m_valid_reg;
        if (item_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_STARTUP;
            sent_reg     <= '0;
            shift_reg    <= '0;
            meas_reg     <= '0;
            ref_reg      <= '0;
            channel_reg  <= '0;
            timebase_reg <= '0;
            led_reg      <= '0;
            start_reg    <= 1'b0;
            rst_line_reg <= 1'b0;
            tx_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (item_take) begin
                phase_reg    <= phase_next;
                sent_reg     <= sent_next;
                shift_reg    <= shift_next;
                meas_reg     <= meas_next;
                ref_reg      <= ref_next;
                channel_reg  <= channel_next;
                timebase_reg <= timebase_next;
                led_reg      <= led_next;
                start_reg    <= start_next;
                rst_line_reg <= rst_line_next;
                tx_reg       <= tx_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

endmodule

`default_nettype wire

[hdl/frequency_counter_measure_controller_core.sv]
// Top level of the frequency counter measure controller.
// Instantiates fcmc_in_reg and fcmc_fsm; depends on fcmc_pkg.
//
//   Channel | Direction | Handshake          | Beat contents
//   s_      | in        | s_valid / s_ready  | one poll: command, valid flag, counts, busy
//   m_      | out       | m_valid / m_ready  | one result: held lines, tx byte, strobe, phase
//
// Polls go in every cycle unless m_ready stalls; results pass the input, then result register.
// The phase register and byte shifter update once per beat, as it leaves the input register.
// Reset is synchronous, active low, and returns the controller to the startup phase.
// A stall on m_ready holds the result register, and the input register keeps one more poll.
`default_nettype none

module frequency_counter_measure_controller_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_meas_valid,
    input  wire logic [31:0] s_meas_count,
    input  wire logic [31:0] s_ref_count,
    input  wire logic        s_uart_busy,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_channel_sel,
    output logic [1:0]       m_timebase_sel,
    output logic [7:0]       m_led_byte,
    output logic             m_start_level,
    output logic             m_reset_level,
    output logic [7:0]       m_tx_byte,
    output logic             m_tx_strobe,
    output logic [1:0]       m_phase
);
    import fcmc_pkg::*;

    poll_t   s_item;
    poll_t   item;
    logic    item_valid;
    logic    item_take;
    result_t result;

    always_comb begin
        s_item.rx_byte    = s_rx_byte;
        s_item.meas_valid = s_meas_valid;
        s_item.meas_count = s_meas_count;
        s_item.ref_count  = s_ref_count;
        s_item.uart_busy  = s_uart_busy;
    end

    fcmc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    fcmc_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_channel_sel  = result.channel_sel;
    assign m_timebase_sel = result.timebase_sel;
    assign m_led_byte     = result.led_byte;
    assign m_start_level  = result.start_level;
    assign m_reset_level  = result.reset_level;
    assign m_tx_byte      = result.tx_byte;
    assign m_tx_strobe    = result.tx_strobe;
    assign m_phase        = result.phase;

endmodule

`default_nettype wire

[bench/fcmc_status_check.sv]
// Prediction and checking for the frequency counter measure controller.
// Watches the poll and result channels and counts mismatches; depends on fcmc_pkg.
module fcmc_status_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_meas_valid,
    input  logic [31:0] s_meas_count,
    input  logic [31:0] s_ref_count,
    input  logic        s_uart_busy,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_channel_sel,
    input  logic [1:0]  m_timebase_sel,
    input  logic [7:0]  m_led_byte,
    input  logic        m_start_level,
    input  logic        m_reset_level,
    input  logic [7:0]  m_tx_byte,
    input  logic        m_tx_strobe,
    input  logic [1:0]  m_phase,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          bytes_strobed
);
    timeunit 1ns;
    timeprecision 1ps;
    import fcmc_pkg::*;

    // Shadow of the controller state, updated once per accepted poll.
    logic [1:0]            ph_code;
    logic [SentWidth-1:0]  sent;
    logic [CountWidth-1:0] shifter;
    logic [CountWidth-1:0] held_meas;
    logic [CountWidth-1:0] held_ref;
    logic [SelWidth-1:0]   chan;
    logic [SelWidth-1:0]   tbase;
    logic [ByteWidth-1:0]  led;
    logic                  start_q;
    logic                  reset_q;
    logic [ByteWidth-1:0]  tx_q;

    result_t status_due[$];
    int      mismatches;
    int      checked;
    int      strobes;

    assign fail_count      = mismatches;
    assign pending         = status_due.size();
    assign results_checked = checked;
    assign bytes_strobed   = strobes;

    task automatic clear_controller();
        ph_code   = PhaseCodeStartup;
        sent      = '0;
        shifter   = '0;
        held_meas = '0;
        held_ref  = '0;
        chan      = '0;
        tbase     = '0;
        led       = '0;
        start_q   = 1'b0;
        reset_q   = 1'b0;
        tx_q      = '0;
    endtask

    task automatic advance_controller(input poll_t p, output result_t r);
        logic [ByteWidth-1:0] masked;
        logic                 strobe;
        strobe = 1'b0;
        case (ph_code)
            PhaseCodeStartup: begin
                ph_code = PhaseCodeIdle;
            end
            PhaseCodeIdle: begin
                if ((p.rx_byte & StartMask) != '0) begin
                    masked  = p.rx_byte & ChannelMask;
                    chan    = masked[1:0];
                    masked  = p.rx_byte & TimebaseMask;
                    tbase   = masked[3:2];
                    led     = p.rx_byte;
                    reset_q = 1'b0;
                    start_q = 1'b1;
                    ph_code = PhaseCodeMeasure;
                end
            end
            PhaseCodeMeasure: begin
                if (p.meas_valid) begin
                    start_q   = 1'b0;
                    held_meas = p.meas_count;
                    held_ref  = p.ref_count;
                    sent      = '0;
                    reset_q   = 1'b1;
                    ph_code   = PhaseCodeTransmit;
                end
            end
            default: begin
                if (!p.uart_busy) begin
                    start_q = 1'b0;
                    if (sent == SentMeasLoad) shifter = held_meas;
                    if (sent == SentRefLoad) shifter = held_ref;
                    if (sent == SentDone) begin
                        tx_q    = '0;
                        ph_code = PhaseCodeIdle;
                    end
                    // The echoed index is three bits wide, so it never matches a finished count.
                    masked = p.rx_byte & IndexMask;
                    if ({1'b0, masked[6:4]} == sent) begin
                        tx_q    = shifter[CountWidth-1 -: ByteWidth];
                        strobe  = 1'b1;
                        shifter = shifter << ByteWidth;
                        sent    = sent + SentOne;
                    end
                end
            end
        endcase
        r.channel_sel  = chan;
        r.timebase_sel = tbase;
        r.led_byte     = led;
        r.start_level  = start_q;
        r.reset_level  = reset_q;
        r.tx_byte      = tx_q;
        r.tx_strobe    = strobe;
        r.phase        = ph_code;
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    initial begin
        mismatches = 0;
        checked    = 0;
        strobes    = 0;
        clear_controller();
    end

    always @(posedge aclk) begin
        poll_t   poll;
        result_t want;
        if (!aresetn) begin
            clear_controller();
            status_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                poll.rx_byte    = s_rx_byte;
                poll.meas_valid = s_meas_valid;
                poll.meas_count = s_meas_count;
                poll.ref_count  = s_ref_count;
                poll.uart_busy  = s_uart_busy;
                advance_controller(poll, want);
                status_due.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    $error("result beat arrived with no prediction waiting");
                    mismatches++;
                end else begin
                    want = status_due.pop_front();
                    check_field("channel_sel", 32'(want.channel_sel), 32'(m_channel_sel));
                    check_field("timebase_sel", 32'(want.timebase_sel), 32'(m_timebase_sel));
                    check_field("led_byte", 32'(want.led_byte), 32'(m_led_byte));
                    check_field("start_level", 32'(want.start_level), 32'(m_start_level));
                    check_field("reset_level", 32'(want.reset_level), 32'(m_reset_level));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(m_tx_byte));
                    check_field("tx_strobe", 32'(want.tx_strobe), 32'(m_tx_strobe));
                    check_field("phase", 32'(want.phase), 32'(m_phase));
                    checked++;
                    if (m_tx_strobe) strobes++;
                end
            end
        end
    end

endmodule

[bench/tb_frequency_counter_measure_controller_core.sv]
// Testbench top for the frequency counter measure controller core.
// Drives polls and result back-pressure; depends on fcmc_pkg and fcmc_status_check.
module tb_frequency_counter_measure_controller_core;
    timeunit 1ns;
    timeprecision 1ps;
    import fcmc_pkg::*;

    localparam int ClkPeriod   = 10;
    localparam int IdlePct     = 7;
    localparam int RandomPolls = 830;
    localparam int HoldCycles  = 80;
    localparam int StallLimit  = 2000;
    localparam int TailCycles  = 10;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        s_meas_valid;
    logic [31:0] s_meas_count;
    logic [31:0] s_ref_count;
    logic        s_uart_busy;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_channel_sel;
    logic [1:0]  m_timebase_sel;
    logic [7:0]  m_led_byte;
    logic        m_start_level;
    logic        m_reset_level;
    logic [7:0]  m_tx_byte;
    logic        m_tx_strobe;
    logic [1:0]  m_phase;

    int fail_count;
    int pending;
    int results_checked;
    int bytes_strobed;

    // Steering copy of the phase and byte count, used only to shape stimulus.
    logic [1:0]           trk_phase;
    logic [SentWidth-1:0] trk_sent;
    int                   polls_sent;
    int                   transfers_done;

    bit quiet;
    int hold_asks;
    int hold_served;

    always #(ClkPeriod / 2) aclk = ~aclk;

    frequency_counter_measure_controller_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_meas_valid   (s_meas_valid),
        .s_meas_count   (s_meas_count),
        .s_ref_count    (s_ref_count),
        .s_uart_busy    (s_uart_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_channel_sel  (m_channel_sel),
        .m_timebase_sel (m_timebase_sel),
        .m_led_byte     (m_led_byte),
        .m_start_level  (m_start_level),
        .m_reset_level  (m_reset_level),
        .m_tx_byte      (m_tx_byte),
        .m_tx_strobe    (m_tx_strobe),
        .m_phase        (m_phase)
    );

    fcmc_status_check u_status_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_meas_valid    (s_meas_valid),
        .s_meas_count    (s_meas_count),
        .s_ref_count     (s_ref_count),
        .s_uart_busy     (s_uart_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_sel   (m_channel_sel),
        .m_timebase_sel  (m_timebase_sel),
        .m_led_byte      (m_led_byte),
        .m_start_level   (m_start_level),
        .m_reset_level   (m_reset_level),
        .m_tx_byte       (m_tx_byte),
        .m_tx_strobe     (m_tx_strobe),
        .m_phase         (m_phase),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .bytes_strobed   (bytes_strobed)
    );

    function automatic logic [31:0] pick_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return $urandom;
    endfunction

    task automatic steer_track(input logic [7:0] rx, input logic mv, input logic busy);
        case (trk_phase)
            PhaseCodeStartup: trk_phase = PhaseCodeIdle;
            PhaseCodeIdle: if (rx[7]) trk_phase = PhaseCodeMeasure;
            PhaseCodeMeasure: begin
                if (mv) begin
                    trk_phase = PhaseCodeTransmit;
                    trk_sent  = '0;
                end
            end
            default: begin
                if (!busy) begin
                    if (trk_sent == SentDone) begin
                        trk_phase = PhaseCodeIdle;
                        transfers_done++;
                    end else if ({1'b0, rx[6:4]} == trk_sent) begin
                        trk_sent = trk_sent + SentOne;
                    end
                end
            end
        endcase
    endtask

    // Offers one poll beat and returns at the edge where it is accepted.
    task automatic send_poll(input logic [7:0] rx, input logic mv, input logic [31:0] mc,
                             input logic [31:0] rc, input logic busy);
        if (!quiet && $urandom_range(0, 99) < IdlePct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_rx_byte    <= rx;
        s_meas_valid <= mv;
        s_meas_count <= mc;
        s_ref_count  <= rc;
        s_uart_busy  <= busy;
        do @(posedge aclk); while (!s_ready);
        steer_track(rx, mv, busy);
        polls_sent++;
    endtask

    // Mostly well-formed polls for the current phase, with about one in ten left fully random.
    task automatic random_poll();
        logic [7:0]  rx;
        logic        mv;
        logic [31:0] mc;
        logic [31:0] rc;
        logic        busy;
        logic [2:0]  idx;
        int          pick;
        rx   = 8'($urandom);
        mv   = 1'($urandom);
        mc   = pick_count();
        rc   = pick_count();
        busy = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick >= 10) begin
            case (trk_phase)
                PhaseCodeIdle:    rx[7] = (pick < 75);
                PhaseCodeMeasure: mv = (pick < 45);
                PhaseCodeTransmit: begin
                    if (trk_sent == SentDone) begin
                        busy = (pick < 30);
                    end else if (pick < 75) begin
                        busy     = 1'b0;
                        rx[6:4]  = trk_sent[2:0];
                    end else if (pick < 88) begin
                        busy = 1'b1;
                    end else begin
                        busy    = 1'b0;
                        idx     = trk_sent[2:0] + 3'($urandom_range(1, 7));
                        rx[6:4] = idx;
                    end
                end
                default: ;
            endcase
        end
        send_poll(rx, mv, mc, rc, busy);
    endtask

    // Result back-pressure: random stalls, plus one long hold-off on request.
    initial begin
        m_ready     = 1'b0;
        hold_served = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_served != hold_asks) begin
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge aclk);
                hold_served++;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= IdlePct);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < StallLimit) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_rx_byte      = '0;
        s_meas_valid   = 1'b0;
        s_meas_count   = '0;
        s_ref_count    = '0;
        s_uart_busy    = 1'b0;
        quiet          = 1'b0;
        hold_asks      = 0;
        trk_phase      = PhaseCodeStartup;
        trk_sent       = '0;
        polls_sent     = 0;
        transfers_done = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Startup swallows one poll whatever it holds.
        send_poll(8'hFF, 1'b1, '1, '1, 1'b1);
        // In idle, bit 6 alone or everything but the start bit does nothing.
        send_poll(8'h40, 1'b1, '0, '0, 1'b0);
        send_poll(8'h7F, 1'b0, '1, '0, 1'b1);
        send_poll(8'hFF, 1'b0, '0, '0, 1'b0);
        // A start bit while measuring is ignored.
        send_poll(8'h80, 1'b0, '1, '1, 1'b0);
        send_poll(8'h00, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        // A busy UART holds the transfer even with the right index echoed.
        send_poll(8'h00, 1'b0, '0, '0, 1'b1);
        for (int i = 0; i < 8; i++) begin
            if (i == 3) send_poll(8'h50, 1'b0, '0, '0, 1'b0);
            send_poll({1'b0, 3'(i), 4'h0}, 1'b0, '0, '0, 1'b0);
        end
        // The closing beat returns to idle; index 7 cannot match a finished count.
        send_poll(8'hF0, 1'b0, '0, '0, 1'b0);
        send_poll(8'h80, 1'b0, '0, '0, 1'b0);
        send_poll(8'h00, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);

        for (int n = 0; n < RandomPolls; n++) begin
            if (n == 200) hold_asks++;
            if (n == 300) quiet = 1'b1;
            if (n == 500) quiet = 1'b0;
            if (n == 600) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            random_poll();
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);

        $display("Run covered %0d poll beats and %0d completed transfers.",
                 polls_sent, transfers_done);
        $display("%0d result beats were checked, %0d of them carrying a UART byte.",
                 results_checked, bytes_strobed);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
hdl/fcmc_pkg.sv
hdl/fcmc_in_reg.sv
hdl/fcmc_fsm.sv
hdl/frequency_counter_measure_controller_core.sv
bench/fcmc_status_check.sv
bench/tb_frequency_counter_measure_controller_core.sv
